[hw/rtl/pps_pkg.sv]
// Shared constants and types for the preemptive priority scheduler.
// No dependencies.
package pps_pkg;

    localparam int SLOT_W    = 3;
    localparam int NUM_SLOTS = 2 ** SLOT_W;
    localparam int TIME_W    = 16;
    localparam int ID_W      = 8;
    localparam int PRIO_W    = 8;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } t_state;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] arrive;
        logic [TIME_W-1:0] burst;
        logic [TIME_W-1:0] remain;
        logic [PRIO_W-1:0] prio;
    } t_slot;

    // controller to datapath
    typedef struct packed {
        logic              load;
        logic              tick_start;
        logic              scan_en;
        logic [SLOT_W-1:0] scan_idx;
        logic              update;
    } t_dp_cmd;

endpackage

[hw/rtl/pps_ctrl.sv]
// Sequencer for the scheduler: decodes a word, walks the slot scan, issues the update.
// Depends on pps_pkg.
module pps_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic               i_req_type,
    output logic               busy,
    output pps_pkg::t_dp_cmd   o_cmd
);
    import pps_pkg::*;

    t_state            r_state, n_state;
    logic [SLOT_W-1:0] r_idx, n_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        busy    = 1'b1;
        o_cmd   = '0;
        o_cmd.scan_idx = r_idx;
        unique case (r_state)
            ST_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    if (i_req_type == REQ_LOAD) begin
                        o_cmd.load = 1'b1;
                    end else begin
                        o_cmd.tick_start = 1'b1;
                        n_idx   = '0;
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                o_cmd.scan_en = 1'b1;
                if (r_idx == SLOT_W'(NUM_SLOTS - 1)) begin
                    n_state = ST_UPDATE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

[hw/rtl/pps_dp.sv]
// Datapath: slot table, time counter, best-candidate compare and result registers.
// Depends on pps_pkg.
module pps_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  pps_pkg::t_dp_cmd            i_cmd,
    input  logic [pps_pkg::SLOT_W-1:0]  i_slot,
    input  logic [pps_pkg::ID_W-1:0]    i_proc_id,
    input  logic [pps_pkg::TIME_W-1:0]  i_arrival,
    input  logic [pps_pkg::TIME_W-1:0]  i_burst,
    input  logic [pps_pkg::PRIO_W-1:0]  i_prio,
    output logic                        o_strobe,
    output logic [pps_pkg::TIME_W-1:0]  o_tick_time,
    output logic                        o_granted,
    output logic [pps_pkg::SLOT_W-1:0]  o_grant_slot,
    output logic [pps_pkg::ID_W-1:0]    o_grant_id,
    output logic                        o_finished,
    output logic [pps_pkg::TIME_W-1:0]  o_wait_time,
    output logic [pps_pkg::TIME_W-1:0]  o_turnaround,
    output logic                        o_all_done
);
    import pps_pkg::*;

    t_slot                r_tab [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] r_active;
    logic [TIME_W-1:0]    r_now;
    logic                 r_found;
    logic [SLOT_W-1:0]    r_best;
    logic [PRIO_W-1:0]    r_best_prio;

    logic                 r_strobe;
    logic [TIME_W-1:0]    r_tick_time;
    logic                 r_granted;
    logic [SLOT_W-1:0]    r_grant_slot;
    logic [ID_W-1:0]      r_grant_id;
    logic                 r_finished;
    logic [TIME_W-1:0]    r_wait_time;
    logic [TIME_W-1:0]    r_turnaround;
    logic                 r_all_done;

    logic [SLOT_W-1:0]    rd_addr;
    t_slot                rd_entry;
    logic                 elig;
    logic                 better;
    logic [TIME_W-1:0]    rem_dec;
    logic                 fin;
    logic [TIME_W-1:0]    end_time;
    logic [TIME_W-1:0]    tat;
    logic [TIME_W-1:0]    wt;
    logic [NUM_SLOTS-1:0] clr_mask;
    logic [NUM_SLOTS-1:0] n_active;

    // single read port: scan index while scanning, chosen slot on update
    assign rd_addr  = i_cmd.update ? r_best : i_cmd.scan_idx;
    assign rd_entry = r_tab[rd_addr];

    assign elig   = r_active[rd_addr] && (rd_entry.arrive <= r_now);
    assign better = elig && (!r_found || (rd_entry.prio < r_best_prio));

    assign rem_dec  = rd_entry.remain - 1'b1;
    assign fin      = r_found && (rem_dec == '0);
    assign end_time = (r_now == TIME_MAX) ? TIME_MAX : r_now + 1'b1;
    assign tat      = end_time - rd_entry.arrive;
    assign wt       = (tat >= rd_entry.burst) ? tat - rd_entry.burst : '0;

    always_comb begin
        clr_mask = '0;
        if (fin) begin
            clr_mask[r_best] = 1'b1;
        end
        n_active = r_active & ~clr_mask;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
            r_now    <= '0;
            r_found  <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.update;
            if (i_cmd.load) begin
                r_active[i_slot] <= (i_burst != '0);
            end
            if (i_cmd.tick_start) begin
                r_found <= 1'b0;
            end else if (i_cmd.scan_en && better) begin
                r_found <= 1'b1;
            end
            if (i_cmd.update) begin
                r_active <= n_active;
                if (r_now != TIME_MAX) begin
                    r_now <= r_now + 1'b1;
                end
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_tab[i_slot] <= '{id: i_proc_id, arrive: i_arrival, burst: i_burst,
                               remain: i_burst, prio: i_prio};
        end else if (i_cmd.update && r_found) begin
            r_tab[r_best].remain <= rem_dec;
        end
        if (i_cmd.scan_en && better) begin
            r_best      <= rd_addr;
            r_best_prio <= rd_entry.prio;
        end
        if (i_cmd.update) begin
            r_tick_time  <= r_now;
            r_granted    <= r_found;
            r_grant_slot <= r_found ? r_best : '0;
            r_grant_id   <= r_found ? rd_entry.id : '0;
            r_finished   <= fin;
            r_wait_time  <= fin ? wt : '0;
            r_turnaround <= fin ? tat : '0;
            r_all_done   <= ~|n_active;
        end
    end

    assign o_strobe     = r_strobe;
    assign o_tick_time  = r_tick_time;
    assign o_granted    = r_granted;
    assign o_grant_slot = r_grant_slot;
    assign o_grant_id   = r_grant_id;
    assign o_finished   = r_finished;
    assign o_wait_time  = r_wait_time;
    assign o_turnaround = r_turnaround;
    assign o_all_done   = r_all_done;

endmodule

[hw/rtl/preemptive_priority_scheduler_top.sv]
// Preemptive priority scheduler. A load word is taken in idle and gives no result.
// A tick word scans every slot in turn through one priority comparator on the slot
// table's single read port, passes one update state, and the result strobe follows,
// in which cycle the next word may already be taken; busy holds off words till then.
// Results cannot be stalled. Synchronous active-low reset clears time and marks
// every slot inactive; slot contents are undefined until loaded.
module preemptive_priority_scheduler_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_req_type,
    input  logic [pps_pkg::SLOT_W-1:0]  i_slot,
    input  logic [pps_pkg::ID_W-1:0]    i_proc_id,
    input  logic [pps_pkg::TIME_W-1:0]  i_arrival,
    input  logic [pps_pkg::TIME_W-1:0]  i_burst,
    input  logic [pps_pkg::PRIO_W-1:0]  i_prio,
    output logic                        o_strobe,
    output logic [pps_pkg::TIME_W-1:0]  o_tick_time,
    output logic                        o_granted,
    output logic [pps_pkg::SLOT_W-1:0]  o_grant_slot,
    output logic [pps_pkg::ID_W-1:0]    o_grant_id,
    output logic                        o_finished,
    output logic [pps_pkg::TIME_W-1:0]  o_wait_time,
    output logic [pps_pkg::TIME_W-1:0]  o_turnaround,
    output logic                        o_all_done
);
    import pps_pkg::*;

    t_dp_cmd cmd;

    pps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_req_type (i_req_type),
        .busy       (busy),
        .o_cmd      (cmd)
    );

    pps_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_slot       (i_slot),
        .i_proc_id    (i_proc_id),
        .i_arrival    (i_arrival),
        .i_burst      (i_burst),
        .i_prio       (i_prio),
        .o_strobe     (o_strobe),
        .o_tick_time  (o_tick_time),
        .o_granted    (o_granted),
        .o_grant_slot (o_grant_slot),
        .o_grant_id   (o_grant_id),
        .o_finished   (o_finished),
        .o_wait_time  (o_wait_time),
        .o_turnaround (o_turnaround),
        .o_all_done   (o_all_done)
    );

    // a tick word must occupy the block
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_req_type == REQ_TICK) |=> busy)
        else $error("tick accepted without going busy");

    // one strobe per tick, never back to back
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe held for more than one cycle");

    a_fin_granted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_finished) |-> (o_granted && o_turnaround >= o_wait_time))
        else $error("completion without grant or wait beyond turnaround");

    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_granted) |-> (o_grant_id == '0 && o_grant_slot == '0))
        else $error("idle tick reports a slot");

endmodule
